>>> hw/rtl/wpsg_pkg.sv
`timescale 1ns / 1ps
package wpsg_pkg;

  localparam int CHANNELS  = 6;
  localparam int WAVE_LEN  = 32;
  localparam int WAVE_AW   = 8;
  localparam int WAVE_DEPTH = CHANNELS * WAVE_LEN;
  localparam int CH_AW     = 3;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_WAVE = 1'b1;

  localparam logic REG_SAMPLE_RATE = 1'b0;
  localparam logic REG_STEREO_MODE = 1'b1;

  localparam logic [16:0] SAMPLE_RATE_RESET = 17'd44100;
  localparam logic [31:0] TONE_NUMERATOR    = 32'd35795456;
  localparam logic [31:0] NOISE_BASE        = 32'd3000;
  localparam logic signed [11:0] AMP_UNIT   = 12'sd702;
  localparam logic signed [15:0] NOISE_AMP  = 16'sd7020;
  localparam logic [19:0] LFSR_RESET        = 20'h631E4;
  localparam logic [19:0] LFSR_TAP          = 20'h00004;
  localparam logic [6:0]  VOL_OFFSET        = 7'd60;
  localparam logic [5:0]  DIV_STEPS         = 6'd32;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_WAVE, ST_DIV1, ST_DIV2, ST_WB, ST_MUL, ST_SCALE
  } state_t;

  typedef struct packed {
    logic [4:0]  pidx;
    logic [31:0] acc;
  } chan_state_t;

  function automatic logic [14:0] vol_lookup(input logic [4:0] idx);
    logic [14:0] v;
    case (idx)
      5'd0:  v = 15'd100;   5'd1:  v = 15'd451;   5'd2:  v = 15'd508;
      5'd3:  v = 15'd573;   5'd4:  v = 15'd646;   5'd5:  v = 15'd728;
      5'd6:  v = 15'd821;   5'd7:  v = 15'd925;   5'd8:  v = 15'd1043;
      5'd9:  v = 15'd1175;  5'd10: v = 15'd1325;  5'd11: v = 15'd1493;
      5'd12: v = 15'd1683;  5'd13: v = 15'd1898;  5'd14: v = 15'd2139;
      5'd15: v = 15'd2411;  5'd16: v = 15'd2718;  5'd17: v = 15'd3064;
      5'd18: v = 15'd3454;  5'd19: v = 15'd3893;  5'd20: v = 15'd4388;
      5'd21: v = 15'd4947;  5'd22: v = 15'd5576;  5'd23: v = 15'd6285;
      5'd24: v = 15'd7085;  5'd25: v = 15'd7986;  5'd26: v = 15'd9002;
      5'd27: v = 15'd10148; 5'd28: v = 15'd11439; 5'd29: v = 15'd12894;
      5'd30: v = 15'd14535; 5'd31: v = 15'd16384;
      default: v = 15'd100;
    endcase
    return v;
  endfunction

  function automatic logic [14:0] volume_of(input logic [3:0] mnib, input logic [4:0] cvol,
                                            input logic [3:0] bnib);
    logic [6:0] sum;
    logic [6:0] d;
    logic [4:0] idx;
    sum = {2'b0, mnib, 1'b0} + {2'b0, cvol} + {2'b0, bnib, 1'b0};
    d = sum - VOL_OFFSET;
    if (sum < VOL_OFFSET) idx = 5'd0;
    else if (d > 7'd31) idx = 5'd31;
    else idx = d[4:0];
    return vol_lookup(idx);
  endfunction

endpackage

>>> hw/rtl/wavetable_psg_channel_synth.sv
`timescale 1ns / 1ps
// Six-channel wavetable sound generator. A wave write gives no word. A tick
// gives one stereo word; a disabled channel, or a tone with a zero period,
// goes from ST_READ straight to ST_MUL, direct mode passes through ST_WAVE,
// and noise and tone use a shared one-bit-per-cycle 32-step divider that
// runs once for noise and twice for tone. No new item is taken until the
// word has gone into the output register. Wave samples and per-channel
// phase state live in synchronous memories. After reset a clearing pass
// over all 192 wave entries zeroes them, during which no item is taken;
// configuration writes are taken at any time.
module wavetable_psg_channel_synth (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [2:0]  channel,
  input  logic [4:0]  wave_index,
  input  logic [4:0]  wave_value,
  input  logic [7:0]  master_balance,
  input  logic [7:0]  control,
  input  logic [7:0]  channel_balance,
  input  logic [15:0] period,
  input  logic [7:0]  noise_control,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [15:0] left_sample,
  output logic signed [15:0] right_sample,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data
);
  import wpsg_pkg::*;

  state_t state, state_next;

  logic [4:0]  wave_mem [WAVE_DEPTH];
  chan_state_t chan_mem [CHANNELS];
  logic [4:0]  wave_q;
  chan_state_t chan_q;

  logic [16:0] sample_rate;
  logic        stereo_mode;

  logic [2:0]  r_ch;
  logic [7:0]  r_mb, r_ctl, r_cb, r_nctl;
  logic [15:0] r_per;

  logic [4:0]  pidx;
  logic [31:0] acc;
  logic signed [15:0] amp;
  logic [14:0] lvol, rvol;
  logic signed [31:0] prod_l, prod_r;

  logic [31:0] dvd;
  logic [20:0] dvs;
  logic [20:0] rem;
  logic [5:0]  cnt;

  logic [19:0] lfsr [2];
  logic        nbit [2];
  logic [7:0]  clr_cnt;

  // Control decodes.
  logic        accept, tick_ok, wave_ok;
  logic        en, direct, is_noise, nc;
  logic [16:0] sr_eff;
  logic [20:0] span;
  logic [21:0] trial;
  logic        ge;
  logic [3:0]  mm, cm;
  logic [14:0] lvol_c, rvol_c;
  logic signed [5:0]  wcentered;
  logic signed [15:0] wave_amp;
  logic        new_bit;
  logic [19:0] lfsr_step;
  chan_state_t wb_data;
  logic        wave_we, chan_we;
  logic [WAVE_AW-1:0] wave_waddr;
  logic [4:0]  wave_wdata;
  logic [CH_AW-1:0] chan_waddr;
  chan_state_t chan_wdata;
  logic        out_load;
  logic signed [31:0] adj_l, adj_r;

  assign cfg_ready = 1'b1;
  assign accept  = in_valid && !in_stall;
  assign tick_ok = (op == OP_TICK) && ({1'b0, channel} < 4'(CHANNELS));
  assign wave_ok = (op == OP_WAVE) && ({1'b0, channel} < 4'(CHANNELS));

  assign en       = r_ctl[7];
  assign direct   = r_ctl[6];
  assign is_noise = ((r_ch == 3'd4) || (r_ch == 3'd5)) && r_nctl[7];
  assign nc       = r_ch[0];
  assign sr_eff   = (sample_rate == 17'd0) ? 17'd1 : sample_rate;
  assign span     = {sr_eff, 3'b000} + {3'b000, sr_eff, 1'b0};

  assign trial = {rem, dvd[31]};
  assign ge    = trial >= {1'b0, dvs};

  assign mm = (r_mb[7:4] > r_mb[3:0]) ? r_mb[7:4] : r_mb[3:0];
  assign cm = (r_cb[7:4] > r_cb[3:0]) ? r_cb[7:4] : r_cb[3:0];
  assign lvol_c = stereo_mode ? volume_of(r_mb[7:4], r_ctl[4:0], r_cb[7:4])
                              : volume_of(mm, r_ctl[4:0], cm);
  assign rvol_c = stereo_mode ? volume_of(r_mb[3:0], r_ctl[4:0], r_cb[3:0]) : 15'd0;

  assign wcentered = $signed({1'b0, wave_q}) - 6'sd16;
  assign wave_amp  = 16'(wcentered * AMP_UNIT);

  // The LFSR steps only when at least one whole sample period has gone by.
  assign new_bit   = (dvd != 32'd0) ? lfsr[nc][19] : nbit[nc];
  assign lfsr_step = lfsr[nc][19] ? (((lfsr[nc] ^ LFSR_TAP) << 1) | 20'd1)
                                  : (lfsr[nc] << 1);
  assign wb_data.pidx = is_noise ? pidx : pidx + dvd[4:0];
  assign wb_data.acc  = {11'd0, rem};

  assign adj_l = prod_l + (prod_l[31] ? 32'sd16383 : 32'sd0);
  assign adj_r = prod_r + (prod_r[31] ? 32'sd16383 : 32'sd0);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_cnt == 8'(WAVE_DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (accept && tick_ok) state_next = ST_READ;
      ST_READ: begin
        if (!en) state_next = ST_MUL;
        else if (direct) state_next = ST_WAVE;
        else if (is_noise) state_next = ST_DIV2;
        else if (r_per == 16'd0) state_next = ST_MUL;
        else state_next = ST_WAVE;
      end
      ST_WAVE:  state_next = direct ? ST_MUL : ST_DIV1;
      ST_DIV1:  if (cnt == 6'd0) state_next = ST_DIV2;
      ST_DIV2:  if (cnt == 6'd0) state_next = ST_WB;
      ST_WB:    state_next = ST_MUL;
      ST_MUL:   state_next = ST_SCALE;
      ST_SCALE: if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_stall   = (state != ST_IDLE);
    out_load   = (state == ST_SCALE) && (!out_valid || !out_stall);
    wave_we    = 1'b0;
    wave_waddr = {channel, wave_index};
    wave_wdata = wave_value;
    chan_we    = 1'b0;
    chan_waddr = r_ch;
    chan_wdata = wb_data;
    case (state)
      ST_CLEAR: begin
        wave_we    = 1'b1;
        wave_waddr = clr_cnt;
        wave_wdata = 5'd0;
        chan_we    = (clr_cnt < 8'(CHANNELS));
        chan_waddr = clr_cnt[CH_AW-1:0];
        chan_wdata = '0;
      end
      ST_IDLE: wave_we = accept && wave_ok;
      ST_READ: begin
        chan_we    = !en;
        chan_wdata = '0;
      end
      ST_WB: chan_we = 1'b1;
      default: ;
    endcase
  end

  // Memories.
  always_ff @(posedge clk) begin
    if (wave_we) wave_mem[wave_waddr] <= wave_wdata;
    wave_q <= wave_mem[{r_ch, (direct ? 5'd0 : chan_q.pidx)}];
  end

  always_ff @(posedge clk) begin
    if (chan_we) chan_mem[chan_waddr] <= chan_wdata;
    if (accept && tick_ok) chan_q <= chan_mem[channel];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_cnt     <= 8'd0;
      sample_rate <= SAMPLE_RATE_RESET;
      stereo_mode <= 1'b1;
      out_valid   <= 1'b0;
      cnt         <= 6'd0;
      for (int i = 0; i < 2; i++) begin
        lfsr[i] <= LFSR_RESET;
        nbit[i] <= 1'b0;
      end
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + 8'd1;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SAMPLE_RATE: sample_rate <= cfg_data;
          REG_STEREO_MODE: stereo_mode <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (state == ST_WB && is_noise) begin
        nbit[nc] <= new_bit;
        if (dvd != 32'd0) lfsr[nc] <= lfsr_step;
      end
      case (state)
        ST_READ: if (en && !direct && is_noise) cnt <= DIV_STEPS;
        ST_WAVE: if (!direct) cnt <= DIV_STEPS;
        ST_DIV1: cnt <= (cnt == 6'd0) ? DIV_STEPS : cnt - 6'd1;
        ST_DIV2: if (cnt != 6'd0) cnt <= cnt - 6'd1;
        default: ;
      endcase
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (accept && tick_ok) begin
      r_ch   <= channel;
      r_mb   <= master_balance;
      r_ctl  <= control;
      r_cb   <= channel_balance;
      r_per  <= period;
      r_nctl <= noise_control;
    end
    case (state)
      ST_READ: begin
        pidx <= chan_q.pidx;
        lvol <= lvol_c;
        rvol <= rvol_c;
        amp  <= 16'sd0;
        if (is_noise) begin
          acc <= chan_q.acc + NOISE_BASE + {18'd0, r_nctl[4:0], 9'd0};
          dvd <= chan_q.acc + NOISE_BASE + {18'd0, r_nctl[4:0], 9'd0};
          dvs <= {4'd0, sr_eff};
        end else begin
          acc <= chan_q.acc;
        end
        rem <= 21'd0;
      end
      ST_WAVE: begin
        amp <= wave_amp;
        dvd <= TONE_NUMERATOR;
        dvs <= {5'd0, r_per};
        rem <= 21'd0;
      end
      ST_DIV1: begin
        if (cnt != 6'd0) begin
          dvd <= {dvd[30:0], ge};
          rem <= ge ? 21'(trial - {1'b0, dvs}) : trial[20:0];
        end else begin
          acc <= acc + dvd;
          dvd <= acc + dvd;
          dvs <= span;
          rem <= 21'd0;
        end
      end
      ST_DIV2: begin
        if (cnt != 6'd0) begin
          dvd <= {dvd[30:0], ge};
          rem <= ge ? 21'(trial - {1'b0, dvs}) : trial[20:0];
        end
      end
      ST_WB: begin
        if (is_noise) amp <= new_bit ? NOISE_AMP : -NOISE_AMP;
      end
      ST_MUL: begin
        prod_l <= 32'(amp * $signed({1'b0, lvol}));
        prod_r <= 32'(amp * $signed({1'b0, rvol}));
      end
      default: ;
    endcase
    if (out_load) begin
      left_sample  <= 16'(adj_l >>> 14);
      right_sample <= 16'(adj_r >>> 14);
    end
  end

endmodule
